### sv/clnb_pkg.sv
package clnb_pkg;

	// field and register widths
	localparam int OP_W     = 3;
	localparam int BYTE_W   = 8;
	localparam int LINE_W   = 2;
	localparam int OFFS_W   = 8;
	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 1;
	localparam int NIB_W    = 4;
	localparam int HOLD_W   = 17;
	localparam int PHASE_W  = 4;
	localparam int INIT_W   = 3;

	// job queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// command codes
	localparam logic [OP_W-1:0] OP_INIT       = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_INSTR   = 3'd1;
	localparam logic [OP_W-1:0] OP_WR_DATA    = 3'd2;
	localparam logic [OP_W-1:0] OP_SAMPLE     = 3'd3;
	localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd4;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_TWO_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 1'b1;
	localparam logic [CFG_W-1:0]     LINE_TWO_BASE_RST = 7'h40;
	localparam logic [CFG_W-1:0]     LINE_WIDTH_RST    = 7'd16;

	// controller constants
	localparam logic [NIB_W-1:0]  FUNC_RESET_NIB = 4'h3;
	localparam logic [NIB_W-1:0]  FUNC_4BIT_NIB  = 4'h2;
	localparam logic [BYTE_W-1:0] SET_DDRAM      = 8'h80;
	localparam logic [INIT_W-1:0] INIT_COUNT     = 3'd5;

	// phase hold times in microseconds
	localparam logic [HOLD_W-1:0] HOLD_POWER_UP = 17'd100000;
	localparam logic [HOLD_W-1:0] HOLD_RESET1   = 17'd10001;
	localparam logic [HOLD_W-1:0] HOLD_RESET2   = 17'd201;
	localparam logic [HOLD_W-1:0] HOLD_RESET3   = 17'd81;
	localparam logic [HOLD_W-1:0] HOLD_SHORT    = 17'd1;

	typedef enum logic [2:0] {
		JOB_ERR,
		JOB_INIT,
		JOB_START,
		JOB_POLL_BUSY,
		JOB_POLL_CLEAR
	} job_kind_t;

	// one classified item as handed to the back end
	typedef struct packed {
		job_kind_t         kind;
		logic [BYTE_W-1:0] wr_byte;
		logic              rs;
		logic              tail;
	} job_t;

	// one pin phase
	typedef struct packed {
		logic [NIB_W-1:0]  nib;
		logic              rs;
		logic              rw;
		logic              e;
		logic              d7in;
		logic [HOLD_W-1:0] hold;
		logic              samp;
		logic              err;
		logic              last;
	} phase_t;

	// instructions queued by init, in send order
	function automatic logic [BYTE_W-1:0] init_instr(input logic [INIT_W-1:0] i);
		logic [BYTE_W-1:0] r;
		unique case (i)
			3'd0: r = 8'h28;
			3'd1: r = 8'h08;
			3'd2: r = 8'h01;
			3'd3: r = 8'h06;
			3'd4: r = 8'h0C;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### sv/clnb_front.sv
module clnb_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [clnb_pkg::OP_W-1:0]      op,
	input  logic [clnb_pkg::BYTE_W-1:0]    value,
	input  logic [clnb_pkg::LINE_W-1:0]    line,
	input  logic [clnb_pkg::OFFS_W-1:0]    offset,
	input  logic                           busy_req,
	input  logic                           cfg_we,
	input  logic [clnb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clnb_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           q_full,
	output logic                           push,
	output clnb_pkg::job_t                 push_job
);
	import clnb_pkg::*;

	logic [CFG_W-1:0]    base_q;
	logic [CFG_W-1:0]    width_q;
	logic                await_q;
	logic [BYTE_W-1:0]   pend_q;
	logic                pend_data_q;
	logic [INIT_W-1:0]   init_rem_q;

	logic                nxt_await;
	logic [BYTE_W-1:0]   nxt_pend;
	logic                nxt_data;
	logic [INIT_W-1:0]   nxt_rem;
	logic [INIT_W-1:0]   rem_m1;
	logic                bad;
	logic                in_range;
	logic [CFG_W-1:0]    pos;
	job_t                job;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign push_job = job;

	// cursor address from line and offset
	always_comb begin
		in_range = offset < {1'b0, width_q};
		pos = '0;
		if (in_range && line == 2'd1)
			pos = offset[CFG_W-1:0];
		else if (in_range && line == 2'd2)
			pos = base_q + offset[CFG_W-1:0];
	end

	// classify the item and work out the next state
	always_comb begin
		job       = '{kind: JOB_ERR, wr_byte: '0, rs: 1'b0, tail: 1'b0};
		nxt_await = await_q;
		nxt_pend  = pend_q;
		nxt_data  = pend_data_q;
		nxt_rem   = init_rem_q;
		rem_m1    = init_rem_q - 3'd1;
		bad = (op > OP_SET_CURSOR) || ((op == OP_SAMPLE) ? !await_q : await_q);
		if (!bad) begin
			unique case (op)
				OP_INIT: begin
					job.kind  = JOB_INIT;
					nxt_rem   = INIT_COUNT;
					nxt_pend  = init_instr(3'd0);
					nxt_data  = 1'b0;
					nxt_await = 1'b1;
				end
				OP_WR_INSTR, OP_WR_DATA: begin
					job.kind  = JOB_START;
					nxt_pend  = value;
					nxt_data  = (op == OP_WR_DATA);
					nxt_await = 1'b1;
				end
				OP_SET_CURSOR: begin
					job.kind  = JOB_START;
					nxt_pend  = SET_DDRAM | {1'b0, pos};
					nxt_data  = 1'b0;
					nxt_await = 1'b1;
				end
				OP_SAMPLE: begin
					if (busy_req) begin
						job.kind = JOB_POLL_BUSY;
					end else begin
						job.kind    = JOB_POLL_CLEAR;
						job.wr_byte = pend_q;
						job.rs      = pend_data_q;
						nxt_await   = 1'b0;
						if (init_rem_q != '0) begin
							if (rem_m1 != '0) begin
								job.tail  = 1'b1;
								nxt_await = 1'b1;
								nxt_pend  = init_instr(INIT_COUNT - rem_m1);
								nxt_data  = 1'b0;
								nxt_rem   = rem_m1;
							end else begin
								nxt_rem = '0;
							end
						end
					end
				end
				default: job.kind = JOB_ERR;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= LINE_TWO_BASE_RST;
			width_q <= LINE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_TWO_BASE: base_q  <= cfg_data;
				CFG_LINE_WIDTH:    width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// poll and init state, updated when an item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q     <= 1'b0;
			pend_q      <= '0;
			pend_data_q <= 1'b0;
			init_rem_q  <= '0;
		end else if (push) begin
			await_q     <= nxt_await;
			pend_q      <= nxt_pend;
			pend_data_q <= nxt_data;
			init_rem_q  <= nxt_rem;
		end
	end

endmodule

### sv/clnb_queue.sv
module clnb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clnb_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output clnb_pkg::job_t head
);
	import clnb_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full       = (cnt_q == QDEPTH[QAW:0]);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// job storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### sv/clnb_back.sv
module clnb_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  clnb_pkg::job_t   head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output clnb_pkg::phase_t out_phase
);
	import clnb_pkg::*;

	logic [PHASE_W-1:0] idx_q;
	logic               out_valid_q;
	phase_t             out_q;
	phase_t             ph;
	logic               load;

	function automatic phase_t wr_ph(input logic [NIB_W-1:0] nib, input logic rs,
	                                 input logic e, input logic [HOLD_W-1:0] hold);
		phase_t p;
		p      = '0;
		p.nib  = nib;
		p.rs   = rs;
		p.e    = e;
		p.hold = hold;
		return p;
	endfunction

	function automatic phase_t rd_ph(input logic e, input logic samp);
		phase_t p;
		p      = '0;
		p.rw   = 1'b1;
		p.e    = e;
		p.d7in = 1'b1;
		p.hold = HOLD_SHORT;
		p.samp = samp;
		return p;
	endfunction

	// pin phase number i of a job
	function automatic phase_t phase_of(input job_t j, input logic [PHASE_W-1:0] i);
		phase_t p;
		logic   fin;
		p   = '0;
		fin = 1'b0;
		unique case (j.kind)
			JOB_ERR: begin
				p.err = 1'b1;
				fin   = 1'b1;
			end
			JOB_INIT: begin
				unique case (i)
					4'd0:             p.hold = HOLD_POWER_UP;
					4'd1, 4'd3, 4'd5: p = wr_ph(FUNC_RESET_NIB, 1'b0, 1'b1, HOLD_SHORT);
					4'd2:             p = wr_ph(FUNC_RESET_NIB, 1'b0, 1'b0, HOLD_RESET1);
					4'd4:             p = wr_ph(FUNC_RESET_NIB, 1'b0, 1'b0, HOLD_RESET2);
					4'd6:             p = wr_ph(FUNC_RESET_NIB, 1'b0, 1'b0, HOLD_RESET3);
					4'd7:             p = wr_ph(FUNC_4BIT_NIB, 1'b0, 1'b1, HOLD_SHORT);
					4'd8:             p = wr_ph(FUNC_4BIT_NIB, 1'b0, 1'b0, HOLD_SHORT);
					default:          p = rd_ph(1'b1, 1'b1);
				endcase
				fin = (i == 4'd9);
			end
			JOB_START: begin
				p   = rd_ph(1'b1, 1'b1);
				fin = 1'b1;
			end
			JOB_POLL_BUSY: begin
				unique case (i)
					4'd0, 4'd2: p = rd_ph(1'b0, 1'b0);
					4'd1:       p = rd_ph(1'b1, 1'b0);
					default:    p = rd_ph(1'b1, 1'b1);
				endcase
				fin = (i == 4'd3);
			end
			JOB_POLL_CLEAR: begin
				unique case (i)
					4'd0, 4'd2: p = rd_ph(1'b0, 1'b0);
					4'd1:       p = rd_ph(1'b1, 1'b0);
					4'd3:       p = wr_ph(j.wr_byte[7:4], j.rs, 1'b1, HOLD_SHORT);
					4'd4:       p = wr_ph(j.wr_byte[7:4], j.rs, 1'b0, HOLD_SHORT);
					4'd5:       p = wr_ph(j.wr_byte[3:0], j.rs, 1'b1, HOLD_SHORT);
					4'd6:       p = wr_ph(j.wr_byte[3:0], j.rs, 1'b0, HOLD_SHORT);
					default:    p = rd_ph(1'b1, 1'b1);
				endcase
				fin = j.tail ? (i == 4'd7) : (i == 4'd6);
			end
			default: begin
				p.err = 1'b1;
				fin   = 1'b1;
			end
		endcase
		p.last = fin;
		return p;
	endfunction

	assign ph        = phase_of(head, idx_q);
	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load && ph.last;
	assign out_valid = out_valid_q;
	assign out_phase = out_q;

	// phase sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			idx_q       <= ph.last ? '0 : idx_q + 1'b1;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// phase payload
	always_ff @(posedge clk) begin
		if (load)
			out_q <= ph;
	end

endmodule

### sv/char_lcd_nibble_interface_top.sv
// Character LCD driver for a 4-bit bus. Each accepted command turns into a run of pin
// phases (D7..D4, RS, RW, E, D7 direction, hold time in us, sample request) with last set
// on the final one: init gives 10, a write or set cursor gives 1 (the first busy sample),
// a busy answer gives 4 and a clear answer gives 7, or 8 when init still has an
// instruction queued. Rejected commands give a single error item. The front end takes
// one command per cycle while the queue has room, into a 4-entry job queue; the back end
// emits one phase per cycle unless out_stall holds it, and back-to-back commands are taken
// as long as the queue has room. Configuration is written only while the block is idle:
// the user is bound to this, and the block itself does not enforce it.
module char_lcd_nibble_interface_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [clnb_pkg::OP_W-1:0]      op,
	input  logic [clnb_pkg::BYTE_W-1:0]    value,
	input  logic [clnb_pkg::LINE_W-1:0]    line,
	input  logic [clnb_pkg::OFFS_W-1:0]    offset,
	input  logic                           busy_req,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [clnb_pkg::NIB_W-1:0]     data_nibble,
	output logic                           register_select,
	output logic                           read_mode,
	output logic                           enable,
	output logic                           d7_input,
	output logic [clnb_pkg::HOLD_W-1:0]    hold_us,
	output logic                           sample_request,
	output logic                           error,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [clnb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clnb_pkg::CFG_W-1:0]     cfg_data
);
	import clnb_pkg::*;

	logic   q_full;
	logic   push;
	job_t   push_job;
	logic   pop;
	logic   head_valid;
	job_t   head;
	phase_t phase;

	// command classification and poll state
	clnb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.value    (value),
		.line     (line),
		.offset   (offset),
		.busy_req (busy_req),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// job queue
	clnb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	// phase sequencer
	clnb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_phase (phase)
	);

	// output fields
	assign data_nibble     = phase.nib;
	assign register_select = phase.rs;
	assign read_mode       = phase.rw;
	assign enable          = phase.e;
	assign d7_input        = phase.d7in;
	assign hold_us         = phase.hold;
	assign sample_request  = phase.samp;
	assign error           = phase.err;
	assign last            = phase.last;

	// an error item always closes its command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last)
		else $error("error item without last");

	// read phases release D7 and drive no data
	a_read_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_mode |-> d7_input && data_nibble == '0 && !register_select)
		else $error("bad read phase");

	// a busy sample is asked for only with E high in read mode, and it ends the command
	a_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_request |-> read_mode && enable && last)
		else $error("bad sample phase");

	// the queue never takes a job while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job queue overflow");

endmodule
